// ----- rtl/sulock_pkg.sv -----
// Shared types, codes and reset constants of the shared unit ownership lock.
// Used by sulock_ctrl, sulock_dp and shared_unit_ownership_lock; no dependencies.
package sulock_pkg;

   localparam int NUM_HARTS_DEF = 2;
   localparam int HOST_W        = 3;
   localparam int ADDR_W        = 32;
   localparam int STATUS_W      = 3;
   localparam int WORD_W        = 7;
   localparam int MASK_W        = 8;
   localparam int CSR_IDX_W     = 2;

   localparam logic [ADDR_W-1:0] ACQ_ADDR_RST = 32'd4;
   localparam logic [ADDR_W-1:0] REL_ADDR_RST = 32'd8;

   // operation codes
   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_STATUS = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACQ_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REL_ADDR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_EXCL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LSU_GATE  = 2'd3;

   // read word outcome and reason codes
   localparam logic [1:0] OUT_FAIL    = 2'd0;
   localparam logic [1:0] OUT_OK      = 2'd1;
   localparam logic [1:0] OUT_OK_WAIT = 2'd2;

   localparam logic [2:0] WHY_NOT_OWNER = 3'd0;
   localparam logic [2:0] WHY_BUSY      = 3'd1;
   localparam logic [2:0] WHY_PENDING   = 3'd2;

   // hart status bits
   localparam int ST_BIT_INFLIGHT = 0;
   localparam int ST_BIT_WANT     = 1;
   localparam int ST_BIT_LSU      = 2;

   localparam logic [1:0] AGE_EXPIRED = 2'd3;
   localparam logic [1:0] AGE_LIVE    = 2'd1;

   typedef enum logic [3:0] {
      LK_FREE     = 4'b0001,
      LK_ACQ_WAIT = 4'b0010,
      LK_LOCKED   = 4'b0100,
      LK_REL_WAIT = 4'b1000
   } lock_state_type;

   typedef enum logic [3:0] {
      CT_IDLE   = 4'b0001,
      CT_APPLY  = 4'b0010,
      CT_UPDATE = 4'b0100,
      CT_DONE   = 4'b1000
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]          operation;
      logic [HOST_W-1:0]   host;
      logic [ADDR_W-1:0]   address;
      logic [STATUS_W-1:0] status_value;
   } req_type;

   typedef struct packed {
      logic              lock_hit;
      logic [WORD_W-1:0] read_word;
      logic [MASK_W-1:0] grant_mask;
   } rsp_type;

   typedef struct packed {
      logic capture;   // latch the accepted request
      logic apply;     // bus access decision, status write, aging
      logic update;    // resolve waits and recompute grants
      logic load_out;  // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic out_busy;  // output register holds a result that is not taken
   } sts_type;

endpackage

// ----- rtl/sulock_ctrl.sv -----
// Sequencer of the shared unit ownership lock: steps one request through
// capture, apply, update and result load. Depends on sulock_pkg.
module sulock_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sulock_pkg::sts_type sts,
   output sulock_pkg::cmd_type cmd
);
   import sulock_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         CT_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = CT_APPLY;
            end
         end
         CT_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = CT_UPDATE;
         end
         CT_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = CT_DONE;
         end
         CT_DONE: begin
            // hold until the output register frees up
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = CT_IDLE;
            end
         end
         default: begin
            state_in = CT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/sulock_dp.sv -----
// Datapath of the shared unit ownership lock: configuration, lock state,
// hart status, round-robin holder, grants and the output register. Depends on sulock_pkg.
module sulock_dp #(
   parameter int NUM_HARTS = sulock_pkg::NUM_HARTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sulock_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sulock_pkg::ADDR_W-1:0]        csr_write_data,
   input  sulock_pkg::req_type                  req_data,
   input  sulock_pkg::cmd_type                  cmd,
   output sulock_pkg::sts_type                  sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sulock_pkg::rsp_type                  rsp_data
);
   import sulock_pkg::*;

   localparam int HIDX_W = $clog2(NUM_HARTS);
   localparam logic [HOST_W:0] NH_CMP = (HOST_W+1)'(NUM_HARTS);
   localparam logic [HIDX_W:0] NH_WRAP = (HIDX_W+1)'(NUM_HARTS);

   // configuration
   logic [ADDR_W-1:0] acq_addr_ff, rel_addr_ff;
   logic              free_excl_ff, lsu_gate_ff;

   // lock and arbiter state
   lock_state_type       lock_ff, lock_in;
   logic [HIDX_W-1:0]    owner_ff, owner_in;
   logic [HIDX_W-1:0]    pend_ff, pend_in;
   logic [STATUS_W-1:0]  status_ff [NUM_HARTS];
   logic [STATUS_W-1:0]  status_in [NUM_HARTS];
   logic [1:0]           age_ff [NUM_HARTS];
   logic [1:0]           age_in [NUM_HARTS];
   logic [NUM_HARTS-1:0] grant_ff, grant_in;
   logic                 hv_ff, hv_in;
   logic [HIDX_W-1:0]    holder_ff, holder_in;
   logic [HIDX_W-1:0]    last_ff, last_in;

   // captured request and per-item result
   req_type           item_ff;
   logic              hit_ff, hit_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic                 host_ok, is_acq, is_hit, op_status, op_tick;
   logic [HIDX_W-1:0]    hidx;
   logic [NUM_HARTS-1:0] wants, inflight, lsu;
   logic                 drained, any_lsu;

   assign host_ok   = {1'b0, item_ff.host} < NH_CMP;
   assign hidx      = item_ff.host[HIDX_W-1:0];
   assign is_acq    = item_ff.address == acq_addr_ff;
   assign is_hit    = (item_ff.operation == OP_ACCESS) && host_ok &&
                      (is_acq || (item_ff.address == rel_addr_ff));
   assign op_status = (item_ff.operation == OP_STATUS) && host_ok;
   assign op_tick   = item_ff.operation == OP_TICK;

   always_comb begin
      for (int h = 0; h < NUM_HARTS; h++) begin
         inflight[h] = status_ff[h][ST_BIT_INFLIGHT];
         lsu[h]      = status_ff[h][ST_BIT_LSU];
         wants[h]    = status_ff[h][ST_BIT_INFLIGHT] |
                       (status_ff[h][ST_BIT_WANT] & (age_ff[h] <= AGE_LIVE));
      end
   end

   assign drained = ~|inflight;
   assign any_lsu = |lsu;

   // apply phase: access decision, status write, aging
   // update phase: resolve waits, then recompute grants
   always_comb begin
      logic [1:0]           outcome;
      logic [2:0]           reason;
      logic                 locked;
      logic                 do_resolve, do_grant;
      lock_state_type       ls_v;
      logic [HIDX_W-1:0]    own_v, last_v, hold_v, scan_idx;
      logic                 hv_v, found;
      logic [HIDX_W:0]      cand;
      logic [NUM_HARTS-1:0] next_grant;

      lock_in   = lock_ff;
      owner_in  = owner_ff;
      pend_in   = pend_ff;
      status_in = status_ff;
      age_in    = age_ff;
      grant_in  = grant_ff;
      hv_in     = hv_ff;
      holder_in = holder_ff;
      last_in   = last_ff;
      hit_in    = hit_ff;
      word_in   = word_ff;

      outcome    = OUT_FAIL;
      reason     = WHY_NOT_OWNER;
      locked     = 1'b0;
      do_resolve = op_status || op_tick;
      do_grant   = do_resolve || is_hit;
      ls_v       = lock_ff;
      own_v      = owner_ff;
      last_v     = last_ff;
      hold_v     = holder_ff;
      hv_v       = hv_ff;
      scan_idx   = '0;
      found      = 1'b0;
      cand       = '0;
      next_grant = '0;

      if (cmd.apply) begin
         hit_in = is_hit;
         if (is_hit) begin
            case (lock_ff)
               LK_FREE: begin
                  if (is_acq) begin
                     if (drained) begin
                        lock_in  = LK_LOCKED;
                        owner_in = hidx;
                        outcome  = OUT_OK;
                     end else begin
                        pend_in = hidx;
                        lock_in = LK_ACQ_WAIT;
                        outcome = OUT_OK_WAIT;
                     end
                  end else begin
                     outcome = (hidx == owner_ff) ? OUT_OK : OUT_FAIL;
                  end
               end
               LK_LOCKED: begin
                  if (is_acq) begin
                     outcome = (hidx == owner_ff) ? OUT_OK : OUT_FAIL;
                     reason  = WHY_BUSY;
                  end else if (hidx == owner_ff) begin
                     if (drained) begin
                        lock_in  = LK_FREE;
                        owner_in = '0;
                        hv_in    = 1'b0;
                        outcome  = OUT_OK;
                     end else begin
                        pend_in = hidx;
                        lock_in = LK_REL_WAIT;
                        outcome = OUT_OK_WAIT;
                     end
                  end
               end
               default: begin
                  reason = WHY_PENDING;
               end
            endcase
            locked  = (lock_in == LK_LOCKED) || (lock_in == LK_REL_WAIT);
            word_in = {locked, owner_in[0], reason, outcome};
         end else begin
            word_in = '0;
         end

         if (op_status) begin
            status_in[hidx] = item_ff.status_value;
            if (item_ff.status_value[ST_BIT_WANT]) begin
               age_in[hidx] = '0;
            end
         end
         if (op_tick) begin
            for (int h = 0; h < NUM_HARTS; h++) begin
               if (age_ff[h] != AGE_EXPIRED) begin
                  age_in[h] = age_ff[h] + 2'd1;
               end
            end
         end
      end

      if (cmd.update && do_grant) begin
         if (do_resolve && drained && (lock_ff == LK_ACQ_WAIT)) begin
            own_v = pend_ff;
            ls_v  = LK_LOCKED;
         end else if (do_resolve && drained && (lock_ff == LK_REL_WAIT)) begin
            own_v = '0;
            ls_v  = LK_FREE;
            hv_v  = 1'b0;
         end

         case (ls_v)
            LK_LOCKED: begin
               next_grant[own_v] = 1'b1;
            end
            LK_FREE: begin
               if (!free_excl_ff) begin
                  next_grant = '1;
               end else begin
                  // drop a holder that no longer wants the unit
                  if (hv_v && !wants[hold_v]) begin
                     last_v = hold_v;
                     hv_v   = 1'b0;
                  end
                  // round-robin: lowest offset after the last served hart wins
                  for (int i = NUM_HARTS; i >= 1; i--) begin
                     cand = {1'b0, last_v} + (HIDX_W+1)'(i);
                     if (cand >= NH_WRAP) begin
                        cand = cand - NH_WRAP;
                     end
                     if (wants[cand[HIDX_W-1:0]]) begin
                        found    = 1'b1;
                        scan_idx = cand[HIDX_W-1:0];
                     end
                  end
                  if (!hv_v && found) begin
                     hv_v   = 1'b1;
                     hold_v = scan_idx;
                  end
                  if (hv_v && !(lsu_gate_ff && any_lsu)) begin
                     next_grant[hold_v] = 1'b1;
                  end
               end
            end
            default: begin
               next_grant = '0;
            end
         endcase

         lock_in   = ls_v;
         owner_in  = own_v;
         hv_in     = hv_v;
         holder_in = hold_v;
         last_in   = last_v;
         grant_in  = next_grant;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acq_addr_ff  <= ACQ_ADDR_RST;
         rel_addr_ff  <= REL_ADDR_RST;
         free_excl_ff <= 1'b1;
         lsu_gate_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ACQ_ADDR:  acq_addr_ff  <= csr_write_data;
            CSR_REL_ADDR:  rel_addr_ff  <= csr_write_data;
            CSR_FREE_EXCL: free_excl_ff <= csr_write_data[0];
            CSR_LSU_GATE:  lsu_gate_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff   <= LK_FREE;
         owner_ff  <= '0;
         pend_ff   <= '0;
         grant_ff  <= '0;
         hv_ff     <= 1'b0;
         holder_ff <= '0;
         last_ff   <= HIDX_W'(NUM_HARTS - 1);
         for (int h = 0; h < NUM_HARTS; h++) begin
            status_ff[h] <= '0;
            age_ff[h]    <= AGE_EXPIRED;
         end
      end else begin
         lock_ff   <= lock_in;
         owner_ff  <= owner_in;
         pend_ff   <= pend_in;
         grant_ff  <= grant_in;
         hv_ff     <= hv_in;
         holder_ff <= holder_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         age_ff    <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      hit_ff  <= hit_in;
      word_ff <= word_in;
      if (cmd.load_out) begin
         rsp_ff.lock_hit   <= hit_ff;
         rsp_ff.read_word  <= word_ff;
         rsp_ff.grant_mask <= MASK_W'(grant_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

// ----- rtl/shared_unit_ownership_lock.sv -----
// Ownership lock and issue arbiter for a vector unit shared by several harts.
// Top level; instantiates sulock_ctrl and sulock_dp, uses sulock_pkg.
//
// Each request (bus access, hart status update or clock tick) goes through
// accept, apply (lock decision, status write, request aging), update (on a
// status update or tick, resolve a pending acquire or release once no hart
// has work in flight; on these and a bus access that hits, recompute the issue
// grants, including the round-robin holder pick) and load into the output
// register. The sequencer in sulock_ctrl works on one request at a time and
// accepts a new one only after loading the last; a stalled result holds it in
// its last step, but once the result sits in the output register the next
// request is taken while it waits to transfer. Every request yields exactly
// one result: lock_hit and read_word report the outcome of a bus access that
// hit the acquire or release offset (zero otherwise) and grant_mask shows the
// grants after the request. Configuration writes through the csr_ port take
// effect at their next use; write them only while idle.
module shared_unit_ownership_lock #(
   parameter int NUM_HARTS = sulock_pkg::NUM_HARTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write port
   input  logic                             csr_write_enable,
   input  logic [sulock_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sulock_pkg::ADDR_W-1:0]    csr_write_data,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sulock_pkg::req_type              req_data,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sulock_pkg::rsp_type              rsp_data
);
   import sulock_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence each request through the datapath
   sulock_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the lock, arbiter and configuration state; drive the result
   sulock_dp #(
      .NUM_HARTS (NUM_HARTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule
